// ===== rtl/magic_length_prefixed_deframer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the deframer
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH
`define MAGIC_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTH
`define LPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPD_ASSERT_SAME(label, ante, cons, msg)
`define LPD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/lpd_pkg.sv =====
// ---------------------------------------------------------------------------
// lpd_pkg
// Shared constants and types of the length-prefixed deframer.
// ---------------------------------------------------------------------------
package lpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_BYTES  = 4;
  localparam int LEN_W      = BYTE_W * LEN_BYTES;
  localparam int LEN_IDX_W  = $clog2(LEN_BYTES);

  localparam logic [BYTE_W-1:0] MARK_FIRST  = 8'h0C;
  localparam logic [BYTE_W-1:0] MARK_SECOND = 8'h1A;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
  } lpd_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;
    logic              is_empty;
  } lpd_result_t;

endpackage

// ===== rtl/lpd_byte_if.sv =====
// ---------------------------------------------------------------------------
// lpd_byte_if
// Valid/ready channel carrying one received stream byte.
// ---------------------------------------------------------------------------
interface lpd_byte_if
  import lpd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lpd_frame_if.sv =====
// ---------------------------------------------------------------------------
// lpd_frame_if
// Valid/ready channel carrying one deframed payload result.
// ---------------------------------------------------------------------------
interface lpd_frame_if
  import lpd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              is_last;
  logic              is_empty;

  modport source (output valid, output payload_byte, output is_last, output is_empty,
                  input ready);
  modport sink   (input valid, input payload_byte, input is_last, input is_empty,
                  output ready);
endinterface

// ===== rtl/lpd_in_reg.sv =====
// ---------------------------------------------------------------------------
// lpd_in_reg
// Input register holding one accepted stream byte until the parser takes it.
// ---------------------------------------------------------------------------
module lpd_in_reg
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              take,
  output lpd_byte_t         held
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
    end
  end

  assign held.valid     = valid_r;
  assign held.data_byte = data_r;

endmodule

// ===== rtl/lpd_parser.sv =====
// ---------------------------------------------------------------------------
// lpd_parser
// Marker hunt, length assembly and payload count; one byte per cycle unless the result register is full.
// ---------------------------------------------------------------------------
`include "magic_length_prefixed_deframer_unit_macros.svh"

module lpd_parser
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lpd_byte_t   held,
  input  logic        out_room,
  output logic        take,
  output logic        res_valid,
  output lpd_result_t res
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_MARK    = 2'd1;
  localparam logic [1:0] PH_LEN     = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [LEN_IDX_W-1:0] IDX_LAST = LEN_IDX_W'(LEN_BYTES - 1);

  logic [1:0]           phase_r;
  logic [1:0]           phase_nxt;
  logic [LEN_IDX_W-1:0] idx_r;
  logic [LEN_IDX_W-1:0] idx_nxt;
  logic [LEN_W-1:0]     rem_r;
  logic [LEN_W-1:0]     rem_nxt;
  logic                 emit;
  logic [BYTE_W-1:0]    b;
  logic [LEN_W-1:0]     len_merged;

  assign b          = held.data_byte;
  assign len_merged = rem_r | (LEN_W'(b) << {idx_r, 3'b000});

  always_comb begin
    phase_nxt        = phase_r;
    idx_nxt          = idx_r;
    rem_nxt          = rem_r;
    emit             = 1'b0;
    res.payload_byte = '0;
    res.is_last      = 1'b0;
    res.is_empty     = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (b == MARK_FIRST) begin
          phase_nxt = PH_MARK;
        end
      end
      PH_MARK: begin
        if (b == MARK_SECOND) begin
          phase_nxt = PH_LEN;
          idx_nxt   = '0;
          rem_nxt   = '0;
        end else if (b != MARK_FIRST) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        rem_nxt = len_merged;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          if (len_merged == '0) begin
            phase_nxt    = PH_HUNT;
            emit         = 1'b1;
            res.is_last  = 1'b1;
            res.is_empty = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_nxt          = rem_r - 1'b1;
        emit             = 1'b1;
        res.payload_byte = b;
        res.is_last      = (rem_r == LEN_W'(1));
        if (rem_r == LEN_W'(1)) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign res_valid = held.valid && emit;
  assign take      = held.valid && (!emit || out_room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      rem_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      rem_r   <= rem_nxt;
    end
  end

  `LPD_ASSERT_SAME(a_payload_nonzero, phase_r == PH_PAYLOAD, rem_r != '0, "payload phase with zero count")
  `LPD_ASSERT_SAME(a_idx_idle, phase_r != PH_LEN, idx_r == '0, "length index not cleared")
  `LPD_ASSERT_NEXT(a_len_done, take && phase_r == PH_LEN && idx_r == IDX_LAST, phase_r == PH_HUNT || phase_r == PH_PAYLOAD, "bad phase after length")
  `LPD_ASSERT_SAME(a_empty_form, res_valid && res.is_empty, res.is_last && res.payload_byte == '0, "malformed empty result")

endmodule

// ===== rtl/lpd_out_reg.sv =====
// ---------------------------------------------------------------------------
// lpd_out_reg
// Result register; holds a transaction until the sink takes it.
// ---------------------------------------------------------------------------
module lpd_out_reg
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  lpd_result_t res,
  output logic        out_room,
  output logic        out_valid,
  input  logic        out_ready,
  output lpd_result_t out_res
);

  logic        valid_r;
  lpd_result_t res_r;

  assign out_room = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_room) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/magic_length_prefixed_deframer_unit.sv =====
// An accepted input byte is registered in the input register; its result is registered before it reaches out_ch.
// One byte per cycle unless out_ch stalls; the parser state update is a single pass.
// Header and dropped bytes produce no result transaction, except the empty result of a zero-length frame.
// Reset (rst_n low, synchronous) empties both registers and returns to hunting.
// ---------------------------------------------------------------------------
// magic_length_prefixed_deframer_unit
// Deframes marker 0x0C 0x1A plus 4-byte little-endian length frames.
// ---------------------------------------------------------------------------
module magic_length_prefixed_deframer_unit
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpd_byte_if.sink    in_ch,
  lpd_frame_if.source out_ch
);

  lpd_byte_t   held;
  logic        take;
  logic        res_valid;
  lpd_result_t res;
  logic        out_room;
  lpd_result_t out_res;

  lpd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .take         (take),
    .held         (held)
  );

  lpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .out_room  (out_room),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_room  (out_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.is_last      = out_res.is_last;
  assign out_ch.is_empty     = out_res.is_empty;

endmodule
